// ===== hdl/i64dec_pkg.sv =====
// Package for the signed integer to decimal ASCII converter.
// Holds the value width, derived digit counts and character codes.
// Has no dependencies.
package i64dec_pkg;

  localparam int VALUE_BITS = 64;
  // Enough decimal digits for any magnitude up to 2^VALUE_BITS - 1.
  localparam int DIGITS = ((VALUE_BITS * 1233) >> 12) + 1;
  localparam int BCD_W = DIGITS * 4;
  localparam int CNT_W = $clog2(VALUE_BITS + 1);
  localparam int IDX_W = $clog2(DIGITS);

  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam logic [7:0] CHAR_ZERO = 8'd48;
  localparam logic [7:0] CHAR_NINE = 8'd57;

endpackage

// ===== hdl/int64_to_decimal_ascii.sv =====
// Signed integer to decimal ASCII converter, top level.
// Uses i64dec_pkg for widths and character codes.
//
// Usage: one signed number enters per transaction on the input channel
// (in_valid, in_stall, number). The block then emits its decimal text one
// character per transaction on the output channel (out_valid, out_stall,
// char_code, is_last): a minus sign for negative values, then the digits
// of the magnitude, most significant first, without leading zeros. The
// last digit carries is_last. Zero gives the single character '0'.
// The magnitude is converted to BCD by a shift-and-add-3 loop that runs
// one bit per cycle over all digits at once, through all VALUE_BITS bits.
// Then, for a negative value, the minus sign is emitted; after that, each
// digit position (DIGITS of them) in turn either drops a leading zero or
// emits a digit. in_stall stays high from acceptance until the last
// character is loaded into the output register, so the next number can be
// taken while that character still waits. While the receiver stalls, the
// output register holds its character and the sequencer waits. Reset
// returns the sequencer to idle and empties the output register.
module int64_to_decimal_ascii (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [63:0]                number,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [7:0]                        char_code,
  output logic                              is_last
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CONV = 3'd1;
  localparam logic [2:0] ST_SIGN = 3'd2;
  localparam logic [2:0] ST_EMIT = 3'd3;

  logic [2:0]                           state;
  logic [i64dec_pkg::VALUE_BITS-1:0]    bin;
  logic [i64dec_pkg::BCD_W-1:0]         bcd;
  logic [i64dec_pkg::BCD_W-1:0]         bcd_adj;
  logic [i64dec_pkg::CNT_W-1:0]         cnt;
  logic [i64dec_pkg::IDX_W-1:0]         idx;
  logic                                 negative;
  logic                                 started;
  logic [i64dec_pkg::VALUE_BITS-1:0]    raw;
  logic [i64dec_pkg::VALUE_BITS-1:0]    mag;
  logic [3:0]                           top_digit;
  logic                                 can_load;
  logic                                 in_take;

  assign in_stall = (state != ST_IDLE);
  assign in_take = in_valid && !in_stall;
  assign can_load = !out_valid || !out_stall;
  assign top_digit = bcd[i64dec_pkg::BCD_W-1 -: 4];

  // Two's complement negation in unsigned arithmetic also covers the most
  // negative value, whose magnitude is 2^(VALUE_BITS-1).
  assign raw = number[i64dec_pkg::VALUE_BITS-1:0];
  assign mag = raw[i64dec_pkg::VALUE_BITS-1] ? (~raw + 1'b1) : raw;

  // Add-3 correction on every BCD digit before the next shift.
  always_comb begin
    logic [3:0] d;
    d = 4'd0;
    for (int i = 0; i < i64dec_pkg::DIGITS; i++) begin
      d = bcd[i*4 +: 4];
      bcd_adj[i*4 +: 4] = (d >= 4'd5) ? (d + 4'd3) : d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_take) begin
            state <= ST_CONV;
          end
        end
        ST_CONV: begin
          if (cnt == i64dec_pkg::CNT_W'(1)) begin
            state <= negative ? ST_SIGN : ST_EMIT;
          end
        end
        ST_SIGN: begin
          if (can_load) begin
            out_valid <= 1'b1;
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if ((started || top_digit != 4'd0 || idx == '0) && can_load) begin
            out_valid <= 1'b1;
            if (idx == '0) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath registers; no reset needed.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_take) begin
          bin <= mag;
          bcd <= '0;
          cnt <= i64dec_pkg::CNT_W'(i64dec_pkg::VALUE_BITS);
          idx <= i64dec_pkg::IDX_W'(i64dec_pkg::DIGITS - 1);
          negative <= raw[i64dec_pkg::VALUE_BITS-1];
          started <= 1'b0;
        end
      end
      ST_CONV: begin
        bcd <= {bcd_adj[i64dec_pkg::BCD_W-2:0], bin[i64dec_pkg::VALUE_BITS-1]};
        bin <= {bin[i64dec_pkg::VALUE_BITS-2:0], 1'b0};
        cnt <= cnt - 1'b1;
      end
      ST_SIGN: begin
        if (can_load) begin
          char_code <= i64dec_pkg::CHAR_MINUS;
          is_last <= 1'b0;
        end
      end
      ST_EMIT: begin
        if (!started && top_digit == 4'd0 && idx != '0) begin
          // Leading zero: drop it without emitting.
          bcd <= {bcd[i64dec_pkg::BCD_W-5:0], 4'd0};
          idx <= idx - 1'b1;
        end else if (can_load) begin
          char_code <= i64dec_pkg::CHAR_ZERO + {4'd0, top_digit};
          is_last <= (idx == '0);
          started <= 1'b1;
          bcd <= {bcd[i64dec_pkg::BCD_W-5:0], 4'd0};
          if (idx != '0) begin
            idx <= idx - 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_take |=> in_stall)
    else $error("input not stalled after a transaction was accepted");

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (char_code == i64dec_pkg::CHAR_MINUS) ||
                  ((char_code >= i64dec_pkg::CHAR_ZERO) &&
                   (char_code <= i64dec_pkg::CHAR_NINE)))
    else $error("output character is neither a digit nor a minus sign");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && char_code == i64dec_pkg::CHAR_MINUS) |-> !is_last)
    else $error("minus sign flagged as last character");

  a_bcd_digit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (top_digit <= 4'd9))
    else $error("BCD conversion produced an invalid digit");

  a_idle_release: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && can_load && idx == '0) |=> (out_valid && is_last && !in_stall))
    else $error("last digit did not end the item");
`endif

endmodule
